FILE: hdl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// shared codes, constants and helpers for the hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

    // image limits and vector placement
    localparam int IMAGE_ADDR_BITS = 24;
    localparam int VECTOR_TOP_BYTE = 3;
    localparam int VEC_SHIFT       = ((VECTOR_TOP_BYTE - 1) % 4) * 8;
    localparam logic [24:0] IMAGE_CAP = (IMAGE_ADDR_BITS >= 24) ? 25'h0FF_FFFF
                                      : (25'd1 << IMAGE_ADDR_BITS);

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_COLON = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM = 3'd3;
    localparam logic [2:0] ERR_EMPTY    = 3'd4;
    localparam logic [2:0] ERR_VEC_LEN  = 3'd5;
    localparam logic [2:0] ERR_START_LEN = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_DATA_TYPE   = 2'd0;
    localparam logic [1:0] CFG_VECTOR_TYPE = 2'd1;
    localparam logic [1:0] CFG_START_TYPE  = 2'd2;

    // characters
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.nib = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.nib = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.nib = 4'(c - 8'h57);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

FILE: hdl/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// result: a result is loaded into the output register in the cycle after its char
// throughput: one char per cycle when not stalled; the whole decode and state update
//   is one combinational pass from the char port into the state and result registers
// reset: async active low, parser waits for a colon, config takes default codes
// ----------------------------------------------------------------------------
module intel_hex_record_parser
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // char input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic [23:0] image_offset,
    output logic [7:0]  record_kind,
    output logic [2:0]  error_code,
    output logic [23:0] image_size,
    output logic [31:0] vector_address,
    output logic [31:0] start_address
);

    // parser phases
    localparam logic [1:0] PH_COLON = 2'd0;
    localparam logic [1:0] PH_PAIRS = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;

    // configuration
    logic [7:0]  data_code_reg;
    logic [7:0]  vector_code_reg;
    logic [7:0]  start_code_reg;

    // parser state
    logic [1:0]  phase_reg,       phase_next;
    logic        nibble_high_reg, nibble_high_next;
    logic [8:0]  pair_count_reg,  pair_count_next;
    logic [7:0]  byte_build_reg,  byte_build_next;
    logic [7:0]  rec_length_reg,  rec_length_next;
    logic [15:0] rec_addr_reg,    rec_addr_next;
    logic [7:0]  rec_type_reg,    rec_type_next;
    logic [7:0]  run_sum_reg,     run_sum_next;
    logic [31:0] pending_reg,     pending_next;
    logic [23:0] packed_size_reg, packed_size_next;
    logic [31:0] vector_reg,      vector_next;
    logic [31:0] start_reg,       start_next;
    logic        stopped_reg,     stopped_next;

    // output register
    logic        out_valid_reg,   out_valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [23:0] offset_reg;
    logic [7:0]  rkind_reg;
    logic [2:0]  err_reg;
    logic [23:0] size_reg;
    logic [31:0] vaddr_reg;
    logic [31:0] saddr_reg;

    // result of this char
    logic        res_fire;
    logic [1:0]  res_kind;
    logic [7:0]  res_byte;
    logic [23:0] res_offset;
    logic [7:0]  res_rkind;
    logic [2:0]  res_err;

    logic                accept_in;
    ihex_pkg::hex_digit_t digit;
    logic [7:0]          byte_val;
    logic [8:0]          data_idx;
    logic                in_data;
    logic [7:0]          sum_ck;
    logic [24:0]         grown_size;

    // the output register is the only buffer: a new char is taken whenever
    // the slot is empty or its item leaves this cycle
    assign in_stall  = out_valid_reg && out_stall;
    assign accept_in = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign digit      = ihex_pkg::hex_value(char_in);
    assign byte_val   = {byte_build_reg[7:4], digit.nib};
    assign data_idx   = pair_count_reg - 9'd4;
    assign in_data    = (pair_count_reg >= 9'd4) && (data_idx < {1'b0, rec_length_reg});
    assign sum_ck     = run_sum_reg + byte_val;
    assign grown_size = {1'b0, packed_size_reg} + {17'd0, rec_length_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        nibble_high_next = nibble_high_reg;
        pair_count_next  = pair_count_reg;
        byte_build_next  = byte_build_reg;
        rec_length_next  = rec_length_reg;
        rec_addr_next    = rec_addr_reg;
        rec_type_next    = rec_type_reg;
        run_sum_next     = run_sum_reg;
        pending_next     = pending_reg;
        packed_size_next = packed_size_reg;
        vector_next      = vector_reg;
        start_next       = start_reg;
        stopped_next     = stopped_reg;

        res_fire   = 1'b0;
        res_kind   = ihex_pkg::KIND_DATA;
        res_byte   = 8'd0;
        res_offset = 24'd0;
        res_rkind  = rec_type_reg;
        res_err    = ihex_pkg::ERR_NONE;

        if (accept_in && !stopped_reg)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    // everything up to the line feed is dropped
                    if (char_in == ihex_pkg::CHAR_LF)
                    begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (char_in != ihex_pkg::CHAR_COLON)
                    begin
                        res_fire     = 1'b1;
                        res_kind     = ihex_pkg::KIND_REJECT;
                        res_rkind    = 8'd0;
                        res_err      = ihex_pkg::ERR_NO_COLON;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        phase_next       = PH_PAIRS;
                        nibble_high_next = 1'b0;
                        pair_count_next  = 9'd0;
                        byte_build_next  = 8'd0;
                        rec_length_next  = 8'd0;
                        rec_addr_next    = 16'd0;
                        rec_type_next    = 8'd0;
                        run_sum_next     = 8'd0;
                        pending_next     = 32'd0;
                    end
                end
                PH_PAIRS:
                begin
                    if (!digit.ok)
                    begin
                        res_fire     = 1'b1;
                        res_kind     = ihex_pkg::KIND_REJECT;
                        res_err      = ihex_pkg::ERR_BAD_HEX;
                        stopped_next = 1'b1;
                    end
                    else if (!nibble_high_reg)
                    begin
                        byte_build_next  = {digit.nib, 4'd0};
                        nibble_high_next = 1'b1;
                    end
                    else
                    begin
                        nibble_high_next = 1'b0;
                        byte_build_next  = byte_val;
                        pair_count_next  = pair_count_reg + 9'd1;
                        priority if (pair_count_reg == 9'd0)
                        begin
                            rec_length_next = byte_val;
                            run_sum_next    = sum_ck;
                        end
                        else if (pair_count_reg == 9'd1)
                        begin
                            rec_addr_next = {byte_val, 8'd0};
                            run_sum_next  = sum_ck;
                        end
                        else if (pair_count_reg == 9'd2)
                        begin
                            rec_addr_next = {rec_addr_reg[15:8], byte_val};
                            run_sum_next  = sum_ck;
                        end
                        else if (pair_count_reg == 9'd3)
                        begin
                            rec_type_next = byte_val;
                            run_sum_next  = sum_ck;
                        end
                        else if (in_data)
                        begin
                            run_sum_next = sum_ck;
                            pending_next = {pending_reg[23:0], byte_val};
                            // data bytes go out tentatively, before the checksum
                            if (rec_type_reg == data_code_reg)
                            begin
                                res_fire   = 1'b1;
                                res_kind   = ihex_pkg::KIND_DATA;
                                res_byte   = byte_val;
                                res_offset = packed_size_reg + {16'd0, data_idx[7:0]};
                            end
                        end
                        else
                        begin
                            // checksum pair: checksum, then length rule, then overflow
                            phase_next = PH_SKIP;
                            res_fire   = 1'b1;
                            res_kind   = ihex_pkg::KIND_REJECT;
                            if (sum_ck != 8'd0)
                            begin
                                res_err = ihex_pkg::ERR_CHECKSUM;
                            end
                            else if (rec_type_reg == data_code_reg)
                            begin
                                if (rec_length_reg == 8'd0)
                                begin
                                    res_err = ihex_pkg::ERR_EMPTY;
                                end
                                else if (grown_size > ihex_pkg::IMAGE_CAP)
                                begin
                                    res_err = ihex_pkg::ERR_OVERFLOW;
                                end
                                else
                                begin
                                    packed_size_next = grown_size[23:0];
                                    res_kind         = ihex_pkg::KIND_ACCEPT;
                                end
                            end
                            else if (rec_type_reg == vector_code_reg)
                            begin
                                if (rec_length_reg != 8'd2)
                                begin
                                    res_err = ihex_pkg::ERR_VEC_LEN;
                                end
                                else
                                begin
                                    vector_next = vector_reg
                                        | ({16'd0, pending_reg[15:0]} << ihex_pkg::VEC_SHIFT)
                                        | {16'd0, rec_addr_reg};
                                    res_kind = ihex_pkg::KIND_ACCEPT;
                                end
                            end
                            else if (rec_type_reg == start_code_reg)
                            begin
                                if (rec_length_reg != 8'd4)
                                begin
                                    res_err = ihex_pkg::ERR_START_LEN;
                                end
                                else
                                begin
                                    start_next = start_reg | pending_reg;
                                    res_kind   = ihex_pkg::KIND_ACCEPT;
                                end
                            end
                            else
                            begin
                                // unknown types pass without action
                                res_kind = ihex_pkg::KIND_ACCEPT;
                            end

                            if (res_kind == ihex_pkg::KIND_REJECT)
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_COLON;
                end
            endcase
        end
    end

    // slot stays full while stalled, reloads on a new result
    assign out_valid_next = res_fire || (out_valid_reg && out_stall);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_code_reg   <= 8'd0;
            vector_code_reg <= 8'd4;
            start_code_reg  <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ihex_pkg::CFG_DATA_TYPE:   data_code_reg   <= cfg_data;
                ihex_pkg::CFG_VECTOR_TYPE: vector_code_reg <= cfg_data;
                ihex_pkg::CFG_START_TYPE:  start_code_reg  <= cfg_data;
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COLON;
            nibble_high_reg <= 1'b0;
            pair_count_reg  <= 9'd0;
            byte_build_reg  <= 8'd0;
            rec_length_reg  <= 8'd0;
            rec_addr_reg    <= 16'd0;
            rec_type_reg    <= 8'd0;
            run_sum_reg     <= 8'd0;
            pending_reg     <= 32'd0;
            packed_size_reg <= 24'd0;
            vector_reg      <= 32'd0;
            start_reg       <= 32'd0;
            stopped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            nibble_high_reg <= nibble_high_next;
            pair_count_reg  <= pair_count_next;
            byte_build_reg  <= byte_build_next;
            rec_length_reg  <= rec_length_next;
            rec_addr_reg    <= rec_addr_next;
            rec_type_reg    <= rec_type_next;
            run_sum_reg     <= run_sum_next;
            pending_reg     <= pending_next;
            packed_size_reg <= packed_size_next;
            vector_reg      <= vector_next;
            start_reg       <= start_next;
            stopped_reg     <= stopped_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            kind_reg   <= res_kind;
            byte_reg   <= res_byte;
            offset_reg <= res_offset;
            rkind_reg  <= res_rkind;
            err_reg    <= res_err;
            size_reg   <= packed_size_next;
            vaddr_reg  <= vector_next;
            saddr_reg  <= start_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign data_byte      = byte_reg;
    assign image_offset   = offset_reg;
    assign record_kind    = rkind_reg;
    assign error_code     = err_reg;
    assign image_size     = size_reg;
    assign vector_address = vaddr_reg;
    assign start_address  = saddr_reg;

`ifndef NO_ASSERTIONS
    // a stop is permanent until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared");

    // input is only held off by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output slot");

    // a shown reject has latched the stop
    a_reject_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == ihex_pkg::KIND_REJECT) |-> stopped_reg)
        else $error("reject without stop");

    // accepted records carry no error
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == ihex_pkg::KIND_ACCEPT)
            |-> (error_code == ihex_pkg::ERR_NONE))
        else $error("accept with error code");
`endif

endmodule
